>>> rtl/shoreline_cell_classifier_macros.svh
// assertion macros for the shoreline cell classifier
`ifndef SHORELINE_CELL_CLASSIFIER_MACROS_SVH
`define SHORELINE_CELL_CLASSIFIER_MACROS_SVH

// condition must hold in the same cycle
`define SCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after
`define SCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/scc_pkg.sv
// shared constants, types and helpers of the shoreline cell classifier
package scc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int DEPTH_BITS = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int GW_W      = 11;
    localparam int GH_W      = 13;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int PEND_W    = $clog2(MAX_WIDTH + 3);
    localparam int CMP_W     = PEND_W + 1;

    localparam int RING_AW    = $clog2(MAX_WIDTH) + 2;
    localparam int RING_DEPTH = 1 << RING_AW;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

    typedef enum logic [1:0] {
        CLS_LAND  = 2'd0,
        CLS_WATER = 2'd1,
        CLS_COAST = 2'd2,
        CLS_EDGE  = 2'd3
    } scc_class_t;

    typedef logic [RING_AW-1:0] ring_addr_t;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             frame_end;
        logic             top_edge;
        logic             bottom_edge;
        logic             left_edge;
        logic             right_edge;
        logic             nw_from_ram;
        logic             nw_fixed;
        logic             ne_fixed;
    } scc_stage_t;

    typedef struct packed {
        logic       we;
        ring_addr_t waddr;
        logic [1:0] wabove;
        logic       wland;
        logic       re;
        ring_addr_t above_addr;
        ring_addr_t self_addr;
        ring_addr_t below_addr;
    } scc_ram_req_t;

    function automatic logic [GW_W-1:0] clamp_width(input logic [GW_W-1:0] v);
        logic [GW_W-1:0] res;
        res = v;
        if (v == '0)
        begin
            res = GW_W'(1);
        end
        else if (v > GW_W'(MAX_WIDTH))
        begin
            res = GW_W'(MAX_WIDTH);
        end
        return res;
    endfunction

    function automatic logic [GH_W-1:0] clamp_height(input logic [GH_W-1:0] v);
        logic [GH_W-1:0] res;
        res = v;
        if (v == '0)
        begin
            res = GH_W'(1);
        end
        else if (v > GH_W'(MAX_HEIGHT))
        begin
            res = GH_W'(MAX_HEIGHT);
        end
        return res;
    endfunction

endpackage

>>> rtl/scc_ram.sv
// generic single-write, single-read ram with registered read data
module scc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/scc_front.sv
// configuration, land compare, ring pointers, position counters and first stage register
module scc_front import scc_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         accept,
    input  logic signed [DEPTH_BITS-1:0] depth_sample,
    input  logic                         drain,
    input  logic                         stage_take,
    output scc_ram_req_t                 ram_req,
    output scc_stage_t                   stage,
    output logic                         pend_empty
);

    logic signed [DEPTH_BITS-1:0] thr_reg, thr_next;
    logic [GW_W-1:0]              width_reg, width_next;
    logic [GH_W-1:0]              height_reg, height_next;
    ring_addr_t                   wr_ptr_reg, wr_ptr_next;
    ring_addr_t                   rd_ptr_reg, rd_ptr_next;
    logic [PEND_W-1:0]            pend_reg, pend_next;
    logic [COL_W-1:0]             ocol_reg, ocol_next;
    logic [ROW_W-1:0]             orow_reg, orow_next;
    logic [1:0]                   hist_reg, hist_next;
    scc_stage_t                   stage_reg, stage_next;

    logic land;
    logic top_edge;
    logic bottom_edge;
    logic left_edge;
    logic right_edge;
    logic pend_full;
    logic nw_arrived;
    logic emit;

    assign land        = depth_sample >= thr_reg;
    assign top_edge    = orow_reg == '0;
    assign left_edge   = ocol_reg == '0;
    assign right_edge  = (GW_W'(ocol_reg) + GW_W'(1)) >= width_reg;
    assign bottom_edge = (GH_W'(orow_reg) + GH_W'(1)) >= height_reg;
    assign pend_full   = CMP_W'(pend_reg) > CMP_W'(width_reg);
    assign nw_arrived  = CMP_W'(pend_reg) >= CMP_W'(width_reg);
    assign pend_empty  = pend_reg == '0;
    assign emit        = drain ? !pend_empty : pend_full;

    always_comb
    begin
        ram_req.we         = accept && !drain;
        ram_req.waddr      = wr_ptr_reg;
        ram_req.wabove     = {land, hist_reg[1]};
        ram_req.wland      = land;
        ram_req.re         = accept;
        ram_req.above_addr = rd_ptr_reg - ring_addr_t'(width_reg) + ring_addr_t'(1);
        ram_req.self_addr  = rd_ptr_reg;
        ram_req.below_addr = rd_ptr_reg + ring_addr_t'(width_reg) - ring_addr_t'(1);
    end

    always_comb
    begin
        thr_next    = thr_reg;
        width_next  = width_reg;
        height_next = height_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        pend_next   = pend_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        hist_next   = hist_reg;
        stage_next  = stage_reg;

        if (accept)
        begin
            if (!drain)
            begin
                wr_ptr_next = wr_ptr_reg + ring_addr_t'(1);
                hist_next   = {hist_reg[0], land};
                if (!emit)
                begin
                    pend_next = pend_reg + PEND_W'(1);
                end
            end
            else if (emit)
            begin
                pend_next = pend_reg - PEND_W'(1);
            end

            if (emit)
            begin
                rd_ptr_next = rd_ptr_reg + ring_addr_t'(1);
                if (right_edge)
                begin
                    ocol_next = '0;
                    orow_next = bottom_edge ? '0 : orow_reg + ROW_W'(1);
                end
                else
                begin
                    ocol_next = ocol_reg + COL_W'(1);
                end
            end

            stage_next.valid       = emit;
            stage_next.row         = orow_reg;
            stage_next.col         = ocol_reg;
            stage_next.frame_end   = bottom_edge && right_edge;
            stage_next.top_edge    = top_edge;
            stage_next.bottom_edge = bottom_edge;
            stage_next.left_edge   = left_edge;
            stage_next.right_edge  = right_edge;
            stage_next.nw_from_ram = drain && nw_arrived;
            stage_next.nw_fixed    = !drain && hist_reg[1];
            stage_next.ne_fixed    = !drain && land;
        end
        else if (stage_take)
        begin
            stage_next.valid = 1'b0;
        end

        // geometry writes restart the frame and drop pending cells
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:
                begin
                    thr_next = cfg_data[DEPTH_BITS-1:0];
                end
                CFG_WIDTH:
                begin
                    width_next  = clamp_width(cfg_data[GW_W-1:0]);
                    ocol_next   = '0;
                    orow_next   = '0;
                    pend_next   = '0;
                    rd_ptr_next = wr_ptr_reg;
                end
                CFG_HEIGHT:
                begin
                    height_next = clamp_height(cfg_data[GH_W-1:0]);
                    ocol_next   = '0;
                    orow_next   = '0;
                    pend_next   = '0;
                    rd_ptr_next = wr_ptr_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= '0;
            width_reg  <= GW_W'(MAX_WIDTH);
            height_reg <= GH_W'(MAX_HEIGHT);
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            pend_reg   <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
            hist_reg   <= '0;
            stage_reg  <= '0;
        end
        else
        begin
            thr_reg    <= thr_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            pend_reg   <= pend_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
            hist_reg   <= hist_next;
            stage_reg  <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

>>> rtl/scc_classify.sv
// neighborhood decision and output register
module scc_classify import scc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  scc_stage_t       stage,
    input  logic [1:0]       above_rd,
    input  logic             self_rd,
    input  logic             below_rd,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [1:0]       cell_class,
    output logic [ROW_W-1:0] row_index,
    output logic [COL_W-1:0] column_index,
    output logic             frame_end,
    output logic             stage_take
);

    logic             out_valid_reg, out_valid_next;
    scc_class_t       class_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             fend_reg;

    scc_class_t cls;
    logic       below_nw;

    assign stage_take = stage.valid && (!out_valid_reg || out_ready);
    assign below_nw   = stage.nw_from_ram ? below_rd : stage.nw_fixed;

    // neighbors visited nw, ne above, then nw, ne below; last write wins
    always_comb
    begin
        cls = CLS_WATER;
        if (self_rd)
        begin
            cls = CLS_LAND;
        end
        else
        begin
            if (stage.top_edge || stage.left_edge)
            begin
                cls = CLS_EDGE;
            end
            else
            begin
                if (above_rd[0])
                begin
                    cls = CLS_COAST;
                end
                if (stage.right_edge)
                begin
                    cls = CLS_EDGE;
                end
                else if (above_rd[1])
                begin
                    cls = CLS_COAST;
                end
            end

            if (stage.bottom_edge || stage.left_edge)
            begin
                cls = CLS_EDGE;
            end
            else
            begin
                if (below_nw)
                begin
                    cls = CLS_COAST;
                end
                if (stage.right_edge)
                begin
                    cls = CLS_EDGE;
                end
                else if (stage.ne_fixed)
                begin
                    cls = CLS_COAST;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (stage_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_take)
        begin
            class_reg <= cls;
            row_reg   <= stage.row;
            col_reg   <= stage.col;
            fend_reg  <= stage.frame_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_class   = class_reg;
    assign row_index    = row_reg;
    assign column_index = col_reg;
    assign frame_end    = fend_reg;

endmodule

>>> rtl/shoreline_cell_classifier.sv
// top level of the shoreline cell classifier
//
// depth samples enter in raster order on the in channel (valid/ready); an item
// with drain set carries no sample and pushes out the oldest pending cell.
// one class per cell leaves on the out channel (valid/ready) together with its
// row, column and a frame_end flag on the grid's last cell.
// a cell is classified once the sample one row plus one cell later arrives,
// or earlier by a drain item; its result passes through the first stage
// register and then the output register.
// one item is taken every cycle while in_ready is high: a land compare and
// the ring access, then the diagonal neighbor decision.
// the land ring holds four rows of single-bit land flags in three copies, so
// the cell, its upper neighbors and its lower-left neighbor read in parallel.
// reset restores the default threshold and geometry and empties the pipeline;
// the ring needs no clearing pass, so the block is ready right after reset.
// while the receiver stalls, the output register holds its result, one more
// item still enters the first stage, and in_ready then drops until the
// output register frees.
// configuration writes take effect at once; the user must make them while idle, which the block leaves unchecked.
`include "shoreline_cell_classifier_macros.svh"

module shoreline_cell_classifier import scc_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DEPTH_BITS-1:0] depth_sample,
    input  logic                         drain,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   cell_class,
    output logic [ROW_W-1:0]             row_index,
    output logic [COL_W-1:0]             column_index,
    output logic                         frame_end
);

    scc_ram_req_t ram_req;
    scc_stage_t   stage;
    logic         pend_empty;
    logic         stage_take;
    logic         accept;
    logic [1:0]   above_rd;
    logic         self_rd;
    logic         below_rd;

    assign in_ready = !stage.valid || !out_valid || out_ready;
    assign accept   = in_valid && in_ready;

    scc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .depth_sample (depth_sample),
        .drain        (drain),
        .stage_take   (stage_take),
        .ram_req      (ram_req),
        .stage        (stage),
        .pend_empty   (pend_empty)
    );

    // entry k of the upper ring holds land flags of cells k and k-2
    scc_ram #(
        .WIDTH (2),
        .DEPTH (RING_DEPTH)
    ) u_above_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wabove),
        .re    (ram_req.re),
        .raddr (ram_req.above_addr),
        .rdata (above_rd)
    );

    scc_ram #(
        .WIDTH (1),
        .DEPTH (RING_DEPTH)
    ) u_self_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wland),
        .re    (ram_req.re),
        .raddr (ram_req.self_addr),
        .rdata (self_rd)
    );

    scc_ram #(
        .WIDTH (1),
        .DEPTH (RING_DEPTH)
    ) u_below_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wland),
        .re    (ram_req.re),
        .raddr (ram_req.below_addr),
        .rdata (below_rd)
    );

    scc_classify u_classify (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .above_rd     (above_rd),
        .self_rd      (self_rd),
        .below_rd     (below_rd),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .cell_class   (cell_class),
        .row_index    (row_index),
        .column_index (column_index),
        .frame_end    (frame_end),
        .stage_take   (stage_take)
    );

    // a drain transfer with nothing pending releases no cell
    `SCC_ASSERT_NEXT(a_empty_drain, accept && drain && pend_empty, !stage.valid, "drain with nothing pending released a cell")
    // the last cell of a grid has no lower row, so water there is open edge
    `SCC_ASSERT_NOW(a_frame_end_edge, out_valid && frame_end && cell_class != CLS_LAND, cell_class == CLS_EDGE, "water at frame end not open edge")
    // the left column has no western neighbors
    `SCC_ASSERT_NOW(a_left_column_edge, out_valid && column_index == '0 && cell_class != CLS_LAND, cell_class == CLS_EDGE, "water in left column not open edge")

endmodule
